// ===== design/ckrle_pkg.sv =====
// Shared word types and register codes for the color-keyed run-length encoder.
package ckrle_pkg;

  typedef struct packed {
    logic [31:0] pixel;
    logic        line_end;
  } pix_word_t;

  typedef struct packed {
    logic [11:0] run_x;
    logic [31:0] run_color;
    logic [12:0] run_length;
    logic        line_last;
    logic [12:0] line_runs;
  } run_word_t;

  // Classified pixel handed from the front to the run tracker.
  typedef struct packed {
    logic [31:0] pixel;
    logic [11:0] x;
    logic        opaque;
    logic        line_end;
  } cls_word_t;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_COLOR_KEY = 1'b0;

endpackage

// ===== design/ckrle_fifo.sv =====
// Small synchronous queue with registered full and empty flags.
module ckrle_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      full   <= 1'b0;
      empty  <= 1'b1;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
        full  <= (count == CW'(DEPTH - 1));
        empty <= 1'b0;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
        full  <= 1'b0;
        empty <= (count == CW'(1));
      end
    end
  end

endmodule

// ===== design/ckrle_front.sv =====
// Front end: tracks the pixel position and classifies each pixel against the key.
module ckrle_front import ckrle_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] color_key,
  input  pix_word_t   pix,
  input  logic        accept,
  output cls_word_t   cls
);

  localparam int unsigned PW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

  logic [PW-1:0] pos_x;
  logic [PW-1:0] pos_x_next;
  logic          in_range;

  assign in_range = (pos_x < PW'(MAX_WIDTH));

  always_comb begin
    cls.pixel    = pix.pixel;
    cls.x        = pos_x[11:0];
    // Pixels past the line limit count as transparent.
    cls.opaque   = in_range && (pix.pixel != color_key);
    cls.line_end = pix.line_end;
    if (pix.line_end) begin
      pos_x_next = '0;
    end else if (in_range) begin
      pos_x_next = pos_x + 1'b1;
    end else begin
      pos_x_next = pos_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
    end else if (accept) begin
      pos_x <= pos_x_next;
    end
  end

endmodule

// ===== design/ckrle_back.sv =====
// Back end: holds the open run, closes runs and writes result words.
module ckrle_back import ckrle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cls_word_t cls,
  input  logic      cls_empty,
  output logic      cls_pop,
  input  logic      res_full,
  output logic      res_push,
  output run_word_t res
);

  logic        run_open;
  logic        adj;
  logic        phase;
  logic [31:0] open_color;
  logic [11:0] open_start;
  logic [12:0] open_length;
  logic [12:0] run_count;

  logic        run_open_next;
  logic        adj_next;
  logic        phase_next;
  logic [31:0] open_color_next;
  logic [11:0] open_start_next;
  logic [12:0] open_length_next;
  logic [12:0] run_count_next;

  logic        go;
  logic        emit_held;
  logic        emit_last;
  logic        emit_empty;

  assign go = !cls_empty && !res_full;

  always_comb begin
    run_open_next    = run_open;
    adj_next         = adj;
    open_color_next  = open_color;
    open_start_next  = open_start;
    open_length_next = open_length;
    run_count_next   = run_count;
    phase_next       = phase;
    emit_held        = 1'b0;
    cls_pop          = 1'b0;
    res_push         = 1'b0;
    res              = '0;

    // Pixel part; skipped on the second pass of a two-word item.
    if (!phase) begin
      if (cls.opaque) begin
        if (run_open && adj && (cls.pixel == open_color)) begin
          open_length_next = open_length + 1'b1;
        end else begin
          emit_held = run_open;
          if (run_open) begin
            run_count_next = run_count + 1'b1;
          end
          run_open_next    = 1'b1;
          open_color_next  = cls.pixel;
          open_start_next  = cls.x;
          open_length_next = 13'd1;
        end
      end
      adj_next = cls.opaque;
    end

    emit_last  = cls.line_end && run_open_next;
    emit_empty = cls.line_end && !run_open_next && (run_count_next == '0);

    if (go) begin
      if (emit_held) begin
        res_push       = 1'b1;
        res.run_x      = open_start;
        res.run_color  = open_color;
        res.run_length = open_length;
        res.line_last  = 1'b0;
        res.line_runs  = run_count_next;
      end else if (emit_last) begin
        res_push       = 1'b1;
        res.run_x      = open_start_next;
        res.run_color  = open_color_next;
        res.run_length = open_length_next;
        res.line_last  = 1'b1;
        res.line_runs  = run_count_next + 1'b1;
      end else if (emit_empty) begin
        res_push       = 1'b1;
        res.line_last  = 1'b1;
      end

      if (emit_held && emit_last) begin
        // Hold the item for a second pass that closes the line.
        phase_next = 1'b1;
      end else begin
        cls_pop    = 1'b1;
        phase_next = 1'b0;
        if (cls.line_end) begin
          run_open_next  = 1'b0;
          adj_next       = 1'b0;
          run_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open  <= 1'b0;
      adj       <= 1'b0;
      phase     <= 1'b0;
      run_count <= '0;
    end else if (go) begin
      run_open  <= run_open_next;
      adj       <= adj_next;
      phase     <= phase_next;
      run_count <= run_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      open_color  <= open_color_next;
      open_start  <= open_start_next;
      open_length <= open_length_next;
    end
  end

endmodule

// ===== design/color_keyed_run_length_encoder_unit.sv =====
// Top level of the color-keyed run-length encoder: config port, front, queues, back.
//
//   channel  direction  handshake           word
//   pixels   in         push / full         pix_word_t  (pixel, line_end)
//   runs     out        pop / empty         run_word_t  (run_x .. line_runs)
//   config   in         APB psel/penable    color_key at byte address 0
//
// One pixel per cycle is accepted while the pixel queue is not full. The run tracker
// also retires one pixel per cycle while that queue is not empty and the result
// queue is not full. A pixel that both closes a run and ends the line with a new run
// takes two tracker passes, one per result word; the queues absorb this.
// Reset clears both queues, the position counter and the open run; the key resets to 0.
// full or a held result stalls only its own side until the queue between fills.
module color_keyed_run_length_encoder_unit import ckrle_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pix_word_t         pix,
  output logic              full,
  input  logic              pop,
  output run_word_t         run,
  output logic              empty,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] color_key;
  logic        cfg_wr;
  logic        accept;
  cls_word_t   cls_in;
  cls_word_t   cls_out;
  logic        cls_empty;
  logic        cls_pop;
  logic        res_full;
  logic        res_push;
  run_word_t   res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_COLOR_KEY) ? color_key : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_key <= '0;
    end else if (cfg_wr && (paddr[2] == REG_COLOR_KEY)) begin
      color_key <= pwdata;
    end
  end

  assign accept = push && !full;

  ckrle_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .color_key(color_key),
    .pix      (pix),
    .accept   (accept),
    .cls      (cls_in)
  );

  ckrle_fifo #(
    .W    ($bits(cls_word_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cls_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (push),
    .wdata(cls_in),
    .full (full),
    .rd   (cls_pop),
    .rdata(cls_out),
    .empty(cls_empty)
  );

  ckrle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cls      (cls_out),
    .cls_empty(cls_empty),
    .cls_pop  (cls_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  ckrle_fifo #(
    .W    ($bits(run_word_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (res_push),
    .wdata(res),
    .full (res_full),
    .rd   (pop),
    .rdata(run),
    .empty(empty)
  );

endmodule

// ===== design/ckrle_checker.sv =====
// Port-level checks for the color-keyed run-length encoder, bound to the top level.
module ckrle_checker import ckrle_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input run_word_t run,
  input logic      pready
);

  // A reset leaves no result word waiting.
  assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

  // Hold a waiting word until it is popped.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(run)))
    else $error("waiting result word changed or vanished");

  // An empty-line word closes its line and counts no runs.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (run.run_length == '0)) |->
      (run.line_last && (run.line_runs == '0) && (run.run_x == '0)))
    else $error("malformed empty-line word");

endmodule

bind color_keyed_run_length_encoder_unit ckrle_checker u_ckrle_checker (
  .clk   (clk),
  .rst   (rst),
  .empty (empty),
  .pop   (pop),
  .run   (run),
  .pready(pready)
);

// ===== tb/tb_color_keyed_run_length_encoder_unit.sv =====
// Testbench for the color-keyed run-length encoder: directed lines, stalls, random lines.
`timescale 1ns / 100ps

module tb_color_keyed_run_length_encoder_unit;
  import ckrle_pkg::*;

  localparam int MAX_W = 4096;
  localparam logic [ADDR_W-1:0] KEY_ADDR = ADDR_W'({REG_COLOR_KEY, 2'b00});

  logic              clk;
  logic              rst;
  logic              push;
  pix_word_t         pix;
  logic              full;
  logic              pop;
  run_word_t         run;
  logic              empty;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  color_keyed_run_length_encoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pix     (pix),
    .full    (full),
    .pop     (pop),
    .run     (run),
    .empty   (empty),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Run tracker mirror
  logic [31:0] key_now;
  logic [12:0] cur_x;
  bit          held;
  logic [31:0] held_color;
  logic [11:0] held_start;
  logic [12:0] held_len;
  logic [12:0] line_count;
  run_word_t   runs_due[$];

  int errors;
  bit idle_on;
  int hold_left;
  int pop_gap;

  always #4 clk = ~clk;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= 100)
      $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $time);
  endtask

  function automatic void close_run(input bit last);
    run_word_t w;
    line_count = line_count + 13'd1;
    w.run_x      = held_start;
    w.run_color  = held_color;
    w.run_length = held_len;
    w.line_last  = last;
    w.line_runs  = line_count;
    runs_due.push_back(w);
    held = 1'b0;
  endfunction

  function automatic void track_pixel(input logic [31:0] p, input logic le);
    run_word_t w;
    if (cur_x < MAX_W && p != key_now) begin
      if (held && p == held_color && int'(held_start) + int'(held_len) == int'(cur_x)) begin
        held_len = held_len + 13'd1;
      end else begin
        if (held)
          close_run(1'b0);
        held       = 1'b1;
        held_color = p;
        held_start = cur_x[11:0];
        held_len   = 13'd1;
      end
    end
    if (cur_x < MAX_W)
      cur_x = cur_x + 13'd1;
    if (le) begin
      if (held) begin
        close_run(1'b1);
      end else if (line_count == 0) begin
        // empty line marker
        w = '0;
        w.line_last = 1'b1;
        runs_due.push_back(w);
      end
      cur_x      = '0;
      held       = 1'b0;
      held_color = '0;
      held_start = '0;
      held_len   = '0;
      line_count = '0;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_pixel(input logic [31:0] p, input logic le);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    push <= 1'b1;
    pix  <= '{pixel: p, line_end: le};
    @(posedge clk);
    while (full) @(posedge clk);
    track_pixel(p, le);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (runs_due.size() != 0) @(negedge clk);
    // let pixels that close no run clear the pipeline
    repeat (12) @(negedge clk);
  endtask

  task automatic write_key(input logic [31:0] k);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEY_ADDR;
    pwdata  <= k;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    key_now = k;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== k)
      report("color_key readback", rd, k);
  endtask

  // Receiver: random pop bursts, plus a long hold when a test asks for one.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      pop_gap = $urandom_range(1, 15) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    run_word_t want;
    if (!rst && pop && !empty) begin
      if (runs_due.size() == 0) begin
        report("unexpected run word, run_x", 32'(run.run_x), 32'd0);
      end else begin
        want = runs_due.pop_front();
        if (run.run_x !== want.run_x)
          report("run_x", 32'(run.run_x), 32'(want.run_x));
        if (run.run_color !== want.run_color)
          report("run_color", run.run_color, want.run_color);
        if (run.run_length !== want.run_length)
          report("run_length", 32'(run.run_length), 32'(want.run_length));
        if (run.line_last !== want.line_last)
          report("line_last", 32'(run.line_last), 32'(want.line_last));
        if (run.line_runs !== want.line_runs)
          report("line_runs", 32'(run.line_runs), 32'(want.line_runs));
      end
    end
  end

  // Key at its reset value of 0.
  task automatic test_special_lines();
    logic [31:0] a, b;
    a = 32'h8000_0001;
    b = 32'h7FFF_FFFE;
    // all-key line
    send_pixel(32'h0, 1'b0);
    send_pixel(32'h0, 1'b0);
    send_pixel(32'h0, 1'b1);
    // one-pixel line
    send_pixel(32'hFFFF_FFFF, 1'b1);
    // key gap splits a run of the same color
    send_pixel(a, 1'b0);
    send_pixel(a, 1'b0);
    send_pixel(32'h0, 1'b0);
    send_pixel(a, 1'b0);
    send_pixel(b, 1'b0);
    send_pixel(b, 1'b1);
    // new run on the last pixel gives two words
    send_pixel(a, 1'b0);
    send_pixel(a, 1'b0);
    send_pixel(b, 1'b1);
    // line closed by a key pixel
    send_pixel(a, 1'b0);
    send_pixel(32'h0, 1'b1);
    send_pixel(32'h0, 1'b1);
    wait_drained();
  endtask

  task automatic test_key_extremes();
    write_key(32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0, 1'b0);
    send_pixel(32'h0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    wait_drained();
    write_key(32'h0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0, 1'b1);
    wait_drained();
  endtask

  // Hold the receiver off while each line of alternating colors yields one word per pixel; the block must stall push.
  task automatic test_backpressure();
    write_key(32'h1234_5678);
    hold_left = 300;
    for (int i = 0; i < 48; i++)
      send_pixel((i % 2) ? 32'hAAAA_5555 : 32'h5555_AAAA, (i % 8) == 7);
    wait_drained();
  endtask

  task automatic random_lines(input int n_items);
    int sent, len, npal, r;
    logic [31:0] pal[3];
    logic [31:0] cur, px;
    sent = 0;
    while (sent < n_items) begin
      len  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      npal = $urandom_range(1, 3);
      for (int i = 0; i < 3; i++)
        pal[i] = $urandom();
      if ($urandom_range(0, 9) == 0)
        pal[0] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      cur = pal[0];
      for (int j = 0; j < len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 15)      px = key_now;
        else if (r < 20) px = $urandom();
        else if (r < 65) px = cur;
        else             px = pal[$urandom_range(0, npal - 1)];
        if (px != key_now)
          cur = px;
        send_pixel(px, j == len - 1);
      end
      sent += len;
    end
    wait_drained();
  endtask

  task automatic test_random();
    write_key($urandom());
    random_lines(500);
    write_key(32'hFFFF_FFFF);
    random_lines(450);
    write_key(32'h0);
    random_lines(450);
    // last part runs at full rate on both sides
    idle_on = 1'b0;
    write_key($urandom());
    random_lines(550);
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    push       = 1'b0;
    pix        = '0;
    pop        = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    errors     = 0;
    idle_on    = 1'b1;
    hold_left  = 0;
    pop_gap    = 0;
    key_now    = '0;
    cur_x      = '0;
    held       = 1'b0;
    held_color = '0;
    held_start = '0;
    held_len   = '0;
    line_count = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_special_lines();
    test_key_extremes();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
design/ckrle_pkg.sv
design/ckrle_fifo.sv
design/ckrle_front.sv
design/ckrle_back.sv
design/color_keyed_run_length_encoder_unit.sv
design/ckrle_checker.sv
tb/tb_color_keyed_run_length_encoder_unit.sv
